### rtl/alr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package alr_pkg;

  localparam int CoordW     = 16;
  localparam int CoordFrac  = 4;
  localparam int GradFrac   = 16;
  localparam int GradW      = 18;
  localparam int MinorW     = 30;
  localparam int MajorW     = 13;
  localparam int PixW       = 14;
  localparam int CovW       = 8;
  localparam int GapW       = 6;
  localparam int DivNumW    = 34;
  localparam int DivDenW    = 17;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic [1:0] {
    PH_FIRST    = 2'd0,
    PH_SECOND   = 2'd1,
    PH_INTERIOR = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_OUT0 = 2'd2,
    ST_OUT1 = 2'd3
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture endpoints, start divider
    logic finish;  // gradient ready, set up end columns
    logic step;    // build next result pair
    logic sel1;    // present second result slot
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic line_active;
  } status_t;

endpackage
`default_nettype wire

### rtl/alr_divider.sv
`timescale 1ns / 1ps
`default_nettype none
module alr_divider
  import alr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [DivNumW-1:0] dividend,
  input  wire logic [DivDenW-1:0] divisor,
  output logic                    done,
  output logic [DivNumW-1:0]      quotient
);

  logic [DivDenW:0]          rem;
  logic [DivNumW-1:0]        quo;
  logic [DivDenW-1:0]        den;
  logic [5:0]                cnt;
  logic                      running;
  logic [DivDenW:0]          trial;
  logic                      fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem[DivDenW-1:0], quo[DivNumW-1]};
    fits  = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= 6'(DivNumW);
      end else if (running) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      den <= divisor;
    end else if (running) begin
      rem <= fits ? trial - {1'b0, den} : trial;
      quo <= {quo[DivNumW-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule
`default_nettype wire

### rtl/alr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module alr_ctrl
  import alr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    op,
  input  wire logic    out_stall,
  input  wire status_t status,
  output logic         in_stall,
  output logic         out_valid,
  output cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (op == OP_START) begin
            state_next = ST_DIV;
          end else begin
            state_next = status.line_active ? ST_OUT0 : ST_OUT1;
          end
        end
      end
      ST_DIV: begin
        if (status.div_done) state_next = ST_IDLE;
      end
      ST_OUT0: begin
        if (!out_stall) state_next = ST_OUT1;
      end
      ST_OUT1: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall   = state != ST_IDLE;
    out_valid  = (state == ST_OUT0) || (state == ST_OUT1);
    cmd.load   = (state == ST_IDLE) && in_valid && (op == OP_START);
    cmd.step   = (state == ST_IDLE) && in_valid && (op == OP_STEP);
    cmd.finish = (state == ST_DIV) && status.div_done;
    cmd.sel1   = state == ST_OUT1;
  end

endmodule
`default_nettype wire

### rtl/alr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module alr_datapath
  import alr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  input  wire logic [CoordW-1:0] start_x,
  input  wire logic [CoordW-1:0] start_y,
  input  wire logic [CoordW-1:0] end_x,
  input  wire logic [CoordW-1:0] end_y,
  output status_t                status,
  output logic [PixW-1:0]        pixel_x,
  output logic [PixW-1:0]        pixel_y,
  output logic [CovW-1:0]        coverage,
  output logic                   last_of_pair,
  output logic                   line_done,
  output logic                   no_pixel
);

  // line setup registers
  logic                     steep;
  logic [CoordW-1:0]        a_maj, a_min, b_maj, b_min;
  logic                     neg;
  logic                     dx_zero;
  logic                     line_active;
  phase_t                   phase;
  logic [MajorW-1:0]        major_first, major_last, major_current;
  logic signed [MinorW-1:0] first_minor, second_minor, accum;
  logic [GapW-1:0]          first_gap, second_gap;
  logic signed [GradW-1:0]  gradient;

  // result slots
  logic [PixW-1:0] px0, py0, px1, py1;
  logic [CovW-1:0] c0, c1;
  logic            done1, none1;

  logic            div_done;
  logic [DivNumW-1:0] quotient;

  // endpoint swap and order
  logic [CoordW-1:0]  adx, ady, sax, say, sbx, sby;
  logic               steep_w, swap_w;
  logic [CoordW-1:0]  l_amaj, l_amin, l_bmaj, l_bmin;
  logic [CoordW-1:0]  dx_w, dy_mag;
  logic               neg_w;
  logic [DivNumW-1:0] div_num;

  always_comb begin
    adx     = (end_x >= start_x) ? end_x - start_x : start_x - end_x;
    ady     = (end_y >= start_y) ? end_y - start_y : start_y - end_y;
    steep_w = ady > adx;
    sax     = steep_w ? start_y : start_x;
    say     = steep_w ? start_x : start_y;
    sbx     = steep_w ? end_y : end_x;
    sby     = steep_w ? end_x : end_y;
    swap_w  = sax > sbx;
    l_amaj  = swap_w ? sbx : sax;
    l_amin  = swap_w ? sby : say;
    l_bmaj  = swap_w ? sax : sbx;
    l_bmin  = swap_w ? say : sby;
    dx_w    = l_bmaj - l_amaj;
    neg_w   = l_bmin < l_amin;
    dy_mag  = neg_w ? l_amin - l_bmin : l_bmin - l_amin;
    // floor of (dy*2^17 + dx) / (2 dx), on magnitudes; dx - 1 in place of dx when negative
    div_num = {1'b0, dy_mag, 17'b0}
            + DivNumW'(neg_w ? dx_w - CoordW'(1) : dx_w);
  end

  alr_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.load),
    .dividend (div_num),
    .divisor  ({dx_w, 1'b0}),
    .done     (div_done),
    .quotient (quotient)
  );

  // gradient and end columns
  logic signed [GradW-1:0]  grad_w;
  logic [MajorW-1:0]        col_a, col_b;
  logic signed [4:0]        off_a, off_b;
  logic signed [GradW+4:0]  prod_a, prod_b;
  logic signed [MinorW-1:0] minor_a, minor_b;
  logic signed [CoordW+4:0] t_a, t_b;

  always_comb begin
    if (dx_zero) begin
      grad_w = GradW'(1 << GradFrac);
    end else if (neg) begin
      grad_w = -$signed(GradW'(quotient[GradW-2:0]));
    end else begin
      grad_w = $signed(GradW'(quotient[GradW-2:0]));
    end
    col_a   = MajorW'((CoordW + 1)'(a_maj) + (CoordW + 1)'(8) >> CoordFrac);
    col_b   = MajorW'((CoordW + 1)'(b_maj) + (CoordW + 1)'(8) >> CoordFrac);
    t_a     = $signed({col_a, 4'b0}) - $signed({5'b0, a_maj});
    t_b     = $signed({col_b, 4'b0}) - $signed({5'b0, b_maj});
    off_a   = t_a[4:0];
    off_b   = t_b[4:0];
    prod_a  = grad_w * off_a;
    prod_b  = grad_w * off_b;
    minor_a = $signed({2'b0, a_min, 12'b0})
            + MinorW'((prod_a + (GradW + 5)'(8)) >>> CoordFrac);
    minor_b = $signed({2'b0, b_min, 12'b0})
            + MinorW'((prod_b + (GradW + 5)'(8)) >>> CoordFrac);
  end

  // pair for the current column
  logic signed [MinorW-1:0] minor_sel;
  logic [MajorW-1:0]        major_sel;
  logic [GapW-1:0]          gap_sel;
  logic [PixW-1:0]          ip, ip1, maj_pix;
  logic [16:0]              f_w, rf_w;
  logic [22:0]              wf, wr;
  logic [31:0]              sf, sr;
  logic                     done_w;

  always_comb begin
    case (phase)
      PH_FIRST: begin
        minor_sel = first_minor;
        major_sel = major_first;
        gap_sel   = first_gap;
      end
      PH_SECOND: begin
        minor_sel = second_minor;
        major_sel = major_last;
        gap_sel   = second_gap;
      end
      default: begin
        minor_sel = accum;
        major_sel = major_current;
        gap_sel   = GapW'(32);
      end
    endcase
    ip      = minor_sel[MinorW-1:GradFrac];
    ip1     = ip + PixW'(1);
    maj_pix = PixW'(major_sel);
    f_w     = {1'b0, minor_sel[GradFrac-1:0]};
    rf_w    = 17'h10000 - f_w;
    wf      = 23'(f_w) * 23'(gap_sel);
    wr      = 23'(rf_w) * 23'(gap_sel);
    // times 255, rounded half up
    sf      = ({wf, 8'b0} - 32'(wf)) + 32'h0010_0000;
    sr      = ({wr, 8'b0} - 32'(wr)) + 32'h0010_0000;
    case (phase)
      PH_FIRST:  done_w = 1'b0;
      PH_SECOND: done_w = (major_first + MajorW'(1)) >= major_last;
      default:   done_w = (major_current + MajorW'(1)) >= major_last;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      phase       <= PH_FIRST;
    end else if (cmd.load) begin
      line_active <= 1'b0;
    end else if (cmd.finish) begin
      line_active <= 1'b1;
      phase       <= PH_FIRST;
    end else if (cmd.step && line_active) begin
      if (done_w) begin
        line_active <= 1'b0;
        phase       <= PH_FIRST;
      end else if (phase == PH_FIRST) begin
        phase <= PH_SECOND;
      end else begin
        phase <= PH_INTERIOR;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      steep   <= steep_w;
      a_maj   <= l_amaj;
      a_min   <= l_amin;
      b_maj   <= l_bmaj;
      b_min   <= l_bmin;
      neg     <= neg_w;
      dx_zero <= dx_w == '0;
    end
    if (cmd.finish) begin
      gradient     <= grad_w;
      major_first  <= col_a;
      major_last   <= col_b;
      first_minor  <= minor_a;
      second_minor <= minor_b;
      first_gap    <= GapW'(32) - GapW'(5'({a_maj[CoordFrac-1:0], 1'b0} + 5'd16));
      second_gap   <= GapW'(5'({b_maj[CoordFrac-1:0], 1'b0} + 5'd16));
    end
    if (cmd.step) begin
      if (line_active) begin
        px0   <= steep ? ip : maj_pix;
        py0   <= steep ? maj_pix : ip;
        px1   <= steep ? ip1 : maj_pix;
        py1   <= steep ? maj_pix : ip1;
        c0    <= sr[28:21];
        c1    <= sf[28:21];
        done1 <= done_w;
        none1 <= 1'b0;
        if (phase == PH_SECOND) begin
          major_current <= major_first + MajorW'(1);
          accum         <= first_minor + MinorW'(gradient);
        end else if (phase == PH_INTERIOR) begin
          major_current <= major_current + MajorW'(1);
          accum         <= accum + MinorW'(gradient);
        end
      end else begin
        px1   <= '0;
        py1   <= '0;
        c1    <= '0;
        done1 <= 1'b0;
        none1 <= 1'b1;
      end
    end
  end

  assign status.div_done    = div_done;
  assign status.line_active = line_active;

  assign pixel_x      = cmd.sel1 ? px1 : px0;
  assign pixel_y      = cmd.sel1 ? py1 : py0;
  assign coverage     = cmd.sel1 ? c1 : c0;
  assign last_of_pair = cmd.sel1 && !none1;
  assign line_done    = cmd.sel1 && done1;
  assign no_pixel     = cmd.sel1 && none1;

endmodule
`default_nettype wire

### rtl/antialiased_line_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none
// Anti-aliased line generator (Wu scheme). A start item (op 0) loads two 12.4
// endpoints; a bit-serial divider computes the gradient, so a start occupies
// the block until the divider is done and yields no result. Each step item
// (op 1) yields one column as two results: the first end column, the second
// end column, then interior columns in rising order; the last one carries
// line_done. A step with no line active gives one result with no_pixel set.
// Items are handled one at a time: a step registers its result pair, then
// each result is held on the output until its transfer is taken.
module antialiased_line_rasterizer
  import alr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              op,
  input  wire logic [CoordW-1:0] start_x,
  input  wire logic [CoordW-1:0] start_y,
  input  wire logic [CoordW-1:0] end_x,
  input  wire logic [CoordW-1:0] end_y,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [PixW-1:0]        pixel_x,
  output logic [PixW-1:0]        pixel_y,
  output logic [CovW-1:0]        coverage,
  output logic                   last_of_pair,
  output logic                   line_done,
  output logic                   no_pixel
);

  cmd_t    cmd;
  status_t status;

  alr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .op        (op),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  alr_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .status       (status),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .coverage     (coverage),
    .last_of_pair (last_of_pair),
    .line_done    (line_done),
    .no_pixel     (no_pixel)
  );

endmodule
`default_nettype wire
